@@ src/tac_pkg.sv @@
// ----------------------------------------------------------------------------
// tac_pkg
// Shared types, constants and calibration curves of the thermistor converter.
// ----------------------------------------------------------------------------
package tac_pkg;

  localparam int CODE_W    = 12;
  localparam int TEMP_W    = 26;
  localparam int CURVE_LEN = 84;
  localparam int K_W       = 7;
  localparam int DEG_W     = 9;
  localparam int SEL_W     = 2;

  typedef logic [CODE_W-1:0]        code_t;
  typedef logic [K_W-1:0]           kidx_t;
  typedef logic signed [DEG_W-1:0]  deg_t;
  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic [SEL_W-1:0]         sel_t;

  // sensor_select codes; every code other than the internal one means external
  localparam sel_t SEL_EXT = 2'd1;
  localparam sel_t SEL_INT = 2'd2;

  // register map
  localparam logic REG_SENSOR_SELECT = 1'b0;

  localparam deg_t  DEG_LOW    = -9'sd10;
  localparam deg_t  DEG_HIGH   = 9'sd156;
  localparam deg_t  DEG_OFFSET = 9'sd12;
  localparam kidx_t K_FIRST    = 7'd0;
  localparam kidx_t K_LAST     = 7'(CURVE_LEN - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_FIN
  } state_t;

  localparam code_t CURVE_EXT [CURVE_LEN] = '{
    12'd3613, 12'd3570, 12'd3525, 12'd3478, 12'd3428, 12'd3375, 12'd3321, 12'd3264,
    12'd3204, 12'd3143, 12'd3080, 12'd3015, 12'd2948, 12'd2880, 12'd2811, 12'd2740,
    12'd2668, 12'd2596, 12'd2524, 12'd2451, 12'd2378, 12'd2304, 12'd2232, 12'd2160,
    12'd2088, 12'd2017, 12'd1947, 12'd1879, 12'd1812, 12'd1746, 12'd1681, 12'd1618,
    12'd1556, 12'd1496, 12'd1438, 12'd1382, 12'd1327, 12'd1274, 12'd1223, 12'd1174,
    12'd1126, 12'd1081, 12'd1036, 12'd994,  12'd953,  12'd914,  12'd877,  12'd840,
    12'd806,  12'd773,  12'd741,  12'd711,  12'd682,  12'd654,  12'd628,  12'd602,
    12'd578,  12'd555,  12'd532,  12'd511,  12'd491,  12'd471,  12'd453,  12'd436,
    12'd418,  12'd403,  12'd387,  12'd372,  12'd358,  12'd331,  12'd331,  12'd320,
    12'd307,  12'd296,  12'd286,  12'd275,  12'd266,  12'd256,  12'd246,  12'd238,
    12'd229,  12'd222,  12'd214,  12'd206
  };

  localparam code_t CURVE_INT [CURVE_LEN] = '{
    12'd3601, 12'd3559, 12'd3514, 12'd3466, 12'd3416, 12'd3364, 12'd3310, 12'd3253,
    12'd3195, 12'd3134, 12'd3072, 12'd3007, 12'd2942, 12'd2875, 12'd2806, 12'd2737,
    12'd2666, 12'd2596, 12'd2524, 12'd2453, 12'd2381, 12'd2309, 12'd2238, 12'd2167,
    12'd2097, 12'd2027, 12'd1959, 12'd1891, 12'd1825, 12'd1760, 12'd1696, 12'd1634,
    12'd1574, 12'd1514, 12'd1457, 12'd1401, 12'd1348, 12'd1295, 12'd1244, 12'd1195,
    12'd1149, 12'd1103, 12'd1059, 12'd1016, 12'd976,  12'd937,  12'd899,  12'd863,
    12'd829,  12'd795,  12'd764,  12'd733,  12'd704,  12'd676,  12'd649,  12'd624,
    12'd599,  12'd575,  12'd553,  12'd531,  12'd511,  12'd491,  12'd472,  12'd454,
    12'd437,  12'd420,  12'd405,  12'd389,  12'd376,  12'd349,  12'd349,  12'd336,
    12'd323,  12'd312,  12'd301,  12'd290,  12'd280,  12'd270,  12'd261,  12'd251,
    12'd243,  12'd234,  12'd227,  12'd220
  };

endpackage

@@ src/tac_in_if.sv @@
// ----------------------------------------------------------------------------
// tac_in_if
// Input channel: one ADC code per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tac_in_if;
  logic              valid;
  logic              ready;
  tac_pkg::code_t    adc_code;

  modport source (output valid, output adc_code, input ready);
  modport sink   (input valid, input adc_code, output ready);
endinterface

@@ src/tac_out_if.sv @@
// ----------------------------------------------------------------------------
// tac_out_if
// Result channel: one temperature per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tac_out_if;
  logic              valid;
  logic              ready;
  tac_pkg::temp_t    temperature_q17;

  modport source (output valid, output temperature_q17, input ready);
  modport sink   (input valid, input temperature_q17, output ready);
endinterface

@@ src/tac_curve_rom.sv @@
// ----------------------------------------------------------------------------
// tac_curve_rom
// Calibration curve ROM, both curves, one registered read per cycle.
// ----------------------------------------------------------------------------
module tac_curve_rom (
  input  logic           clk,
  input  logic           rd_int,
  input  tac_pkg::kidx_t rd_k,
  output tac_pkg::code_t rd_data
);
  import tac_pkg::*;

  code_t rd_data_r;

  always_ff @(posedge clk) begin
    if (rd_int) begin
      rd_data_r <= CURVE_INT[rd_k];
    end else begin
      rd_data_r <= CURVE_EXT[rd_k];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/tac_div.sv @@
// ----------------------------------------------------------------------------
// tac_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tac_div #(
  parameter int NUMW = 30,
  parameter int DENW = 12
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [NUMW-1:0] num,
  input  logic [DENW-1:0] den,
  output logic            done,
  output logic [NUMW-1:0] quot
);
  localparam int CNT_W = $clog2(NUMW + 1);

  logic [NUMW-1:0]  q_r, q_nxt;
  logic [DENW-1:0]  rem_r, rem_nxt;
  logic [DENW-1:0]  den_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DENW:0]    trial;

  assign trial = {rem_r, q_r[NUMW-1]};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(NUMW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // subtract when the shifted remainder reaches the divisor
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DENW'(trial - {1'b0, den_r});
        q_nxt   = {q_r[NUMW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DENW-1:0];
        q_nxt   = {q_r[NUMW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

@@ src/thermistor_adc_to_celsius.sv @@
// ----------------------------------------------------------------------------
// thermistor_adc_to_celsius
// Thermistor ADC code to temperature by table search and interpolation.
// ----------------------------------------------------------------------------
// Converts one 12-bit thermistor code per item into a signed temperature with
// FRAC_BITS fraction bits on a 26-bit result (-10 C to 156 C). The curve,
// external or internal sensor, comes from sensor_select at byte address 0
// (only code 2 picks the internal curve). The block handles one item at a
// time: a linear search walks the 84-entry curve ROM one entry per cycle,
// then a restoring divider produces the interpolation fraction one bit per
// cycle. An item is accepted in the idle state. The search stops at the first
// curve entry that the code reaches (index 0 to 83), or at the last entry when
// it reaches none. The divider runs only when the code interpolates, and the
// result register is loaded after that. A code that clamps at -10 C or at
// 156 C skips the divider. A finished result waits in its output register
// while the next item may already be accepted.
// ----------------------------------------------------------------------------
module thermistor_adc_to_celsius #(
  parameter int FRAC_BITS = 17
) (
  input  logic                 clk,
  input  logic                 rst_n,
  tac_in_if.sink               in_ch,
  tac_out_if.source            out_ch,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import tac_pkg::*;

  // numerator is 2*(t[k-1]-x) << FRAC_BITS, divisor is one curve step
  localparam int NUMW = CODE_W + 1 + FRAC_BITS;
  localparam int SUMW = FRAC_BITS + DEG_W + 1;
  localparam int FRW  = FRAC_BITS + 2;
  localparam int EXTW = SUMW + TEMP_W;

  state_t state_r, state_nxt;

  sel_t   sel_r;
  code_t  code_r;
  logic   int_r;
  kidx_t  k_r;
  code_t  prev_r;
  deg_t   deg_r;
  logic [FRW-1:0] frac_r;

  logic   out_valid_r;
  temp_t  out_temp_r;

  // control decoded from the state
  logic   in_take;
  logic   rom_int;
  kidx_t  rom_k;
  code_t  rom_data;
  logic   hit;
  logic   div_start;
  logic   div_done;
  logic [NUMW-1:0] div_quot;
  logic   out_load;
  logic   cfg_wr;

  logic signed [SUMW-1:0] base;
  logic signed [SUMW-1:0] sum;
  logic signed [EXTW-1:0] sum_ext;

  // --------------------------------------------------------------------------
  // Configuration port: zero-wait APB, one register.
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SENSOR_SELECT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= SEL_EXT;
    end else if (cfg_wr) begin
      sel_r <= pwdata[SEL_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_SENSOR_SELECT) begin
      prdata = {{(32-SEL_W){1'b0}}, sel_r};
    end
  end

  // --------------------------------------------------------------------------
  // Curve ROM and divider.
  // --------------------------------------------------------------------------
  tac_curve_rom u_rom (
    .clk     (clk),
    .rd_int  (rom_int),
    .rd_k    (rom_k),
    .rd_data (rom_data)
  );

  tac_div #(
    .NUMW (NUMW),
    .DENW (CODE_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({CODE_W'(prev_r - code_r), {(FRAC_BITS+1){1'b0}}}),
    .den   (CODE_W'(prev_r - rom_data)),
    .done  (div_done),
    .quot  (div_quot)
  );

  // the search stops at the first entry that the code reaches
  assign hit = (code_r >= rom_data);

  // --------------------------------------------------------------------------
  // Sequencer: next state.
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit && (k_r != K_FIRST)) begin
          state_nxt = ST_DIV;
        end else if (hit || (k_r == K_LAST)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs.
  // --------------------------------------------------------------------------
  always_comb begin
    in_take   = 1'b0;
    rom_int   = int_r;
    rom_k     = K_FIRST;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        // prime the first entry of the chosen curve
        in_take = 1'b1;
        rom_int = (sel_r == SEL_INT);
      end
      ST_SCAN: begin
        // read ahead one entry; hold at the last entry
        rom_k     = (k_r == K_LAST) ? K_LAST : K_W'(k_r + 1'b1);
        div_start = hit && (k_r != K_FIRST);
      end
      ST_DIV: begin
        rom_k = k_r;
      end
      ST_FIN: begin
        out_load = !out_valid_r || out_ch.ready;
      end
      default: begin
        in_take = 1'b0;
      end
    endcase
  end

  assign in_ch.ready = in_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Item datapath.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        code_r <= in_ch.adc_code;
        int_r  <= (sel_r == SEL_INT);
        k_r    <= K_FIRST;
      end
      ST_SCAN: begin
        if (hit) begin
          // code above the first entry clamps low, else interpolate
          if (k_r == K_FIRST) begin
            deg_r <= DEG_LOW;
          end else begin
            deg_r <= $signed({1'b0, k_r, 1'b0}) - DEG_OFFSET;
          end
          frac_r <= '0;
        end else if (k_r == K_LAST) begin
          // code below the last entry clamps high
          deg_r  <= DEG_HIGH;
          frac_r <= '0;
        end else begin
          prev_r <= rom_data;
          k_r    <= K_W'(k_r + 1'b1);
        end
      end
      ST_DIV: begin
        if (div_done) begin
          frac_r <= div_quot[FRW-1:0];
        end
      end
      default: begin
        k_r <= k_r;
      end
    endcase
  end

  // whole degrees plus the fraction, wrapped into the result width
  assign base    = $signed({{(SUMW-DEG_W){deg_r[DEG_W-1]}}, deg_r}) <<< FRAC_BITS;
  assign sum     = base + $signed({{(SUMW-FRW){1'b0}}, frac_r});
  assign sum_ext = {{(EXTW-SUMW){sum[SUMW-1]}}, sum};

  // --------------------------------------------------------------------------
  // Output register: hold the item until the sink takes it.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_temp_r <= sum_ext[TEMP_W-1:0];
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.temperature_q17 = out_temp_r;

endmodule
